// ===== hw/rtl/pn2d_pkg.sv =====
// Package: widths, fixed-point helpers and gradient function for the 2D noise unit.
`timescale 1ns / 1ps
package pn2d_pkg;

    localparam int COORD_FRAC_BITS = 16;
    localparam int FRAC_SH_R = (COORD_FRAC_BITS >= 16) ? COORD_FRAC_BITS - 16 : 0;
    localparam int FRAC_SH_L = (COORD_FRAC_BITS < 16) ? 16 - COORD_FRAC_BITS : 0;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_EVAL  = 1'b1;

    localparam int PERM_DEPTH = 256;
    localparam int PERM_WIDTH = 8;

    typedef logic signed [20:0] fix_t;
    typedef logic signed [18:0] dot_t;

    function automatic logic [15:0] frac_q16(logic [31:0] raw);
        return 16'((raw >> FRAC_SH_R) << FRAC_SH_L);
    endfunction

    // floor(t * a / 2^16)
    function automatic fix_t qmul(logic [15:0] t, fix_t a);
        logic signed [37:0] p;
        p = $signed({1'b0, t}) * a;
        return fix_t'(p >>> 16);
    endfunction

    function automatic dot_t grad(logic [3:0] h, logic signed [17:0] x,
                                  logic signed [17:0] y);
        logic signed [18:0] u;
        logic signed [18:0] v;
        u = (h < 4'd8) ? 19'(x) : 19'(y);
        if (h < 4'd4)
            v = 19'(y);
        else if (h == 4'd12 || h == 4'd14)
            v = 19'(x);
        else
            v = '0;
        return (h[0] ? -u : u) + (h[1] ? -v : v);
    endfunction

endpackage

// ===== hw/rtl/pn2d_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module pn2d_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/perlin_noise_2d_unit.sv =====
// Top level: pipelined 2D improved Perlin noise evaluator with permutation table.
`timescale 1ns / 1ps
// Usage:
//   A word is taken at each rising edge where start is high; busy is always low,
//   so one word may be issued every cycle.
//   kind = 0 writes table_value into permutation entry table_index; no result.
//   kind = 1 evaluates noise at signed fixed-point (x_coord, y_coord).
//   The result appears on noise_value with done high for one cycle, once the
//   evaluate word has passed all pipeline stages; results leave in issue order.
//   Throughput is one word per cycle. The table is held in six copies (two for
//   the row lookup, four for the corner lookups), all written by each table
//   write, so every lookup has its own read port.
//   A table write takes effect for every evaluate word issued after it.
//   The receiver cannot stall; done is a plain strobe.
//   Reset clears the pipeline valid bits; table contents are undefined until
//   loaded by software and must be written before use.
module perlin_noise_2d_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                kind,
    input  logic [7:0]          table_index,
    input  logic [7:0]          table_value,
    input  logic signed [31:0]  x_coord,
    input  logic signed [31:0]  y_coord,
    output logic signed [18:0]  noise_value,
    output logic                done
);
    import pn2d_pkg::*;

    localparam int STAGES = 9;

    logic       acc;
    logic       tbl_we;
    logic       eval_in;
    logic [7:0] cy_in;
    logic [7:0] py0;
    logic [7:0] py1;
    logic [7:0] h_aa;
    logic [7:0] h_ab;
    logic [7:0] h_ba;
    logic [7:0] h_bb;
    logic [7:0] a_aa;
    logic [7:0] a_ab;
    logic [7:0] a_ba;
    logic [7:0] a_bb;

    logic [STAGES-1:0] vld_reg;
    logic [STAGES-1:0] vld_next;

    logic [15:0] fx1_reg, fy1_reg, fx2_reg, fy2_reg, fx3_reg, fy3_reg, fx4_reg, fy4_reg;
    logic [7:0]  cx1_reg;
    fix_t ax_reg, ay_reg, bx_reg, by_reg, cxf_reg, cyf_reg, dx_reg, dy_reg;
    fix_t u5_reg, v5_reg, v6_reg, v7_reg;
    dot_t daa3_reg, dab3_reg, dba3_reg, dbb3_reg;
    dot_t daa4_reg, dab4_reg, dba4_reg, dbb4_reg;
    dot_t daa5_reg, dab5_reg, dba5_reg, dbb5_reg;
    dot_t daa6_reg, dab6_reg;
    logic signed [39:0] p0_reg, p1_reg, pr_reg;
    fix_t n0_reg, n1_reg, n0_8_reg;
    logic signed [18:0] out_reg;

    logic signed [17:0] x0, y0, x1, y1;

    assign busy    = 1'b0;
    assign acc     = start && !busy;
    assign tbl_we  = acc && (kind == KIND_WRITE);
    assign eval_in = acc && (kind == KIND_EVAL);
    assign cy_in   = 8'(y_coord >>> COORD_FRAC_BITS);

    assign a_aa = cx1_reg + py0;
    assign a_ab = cx1_reg + py1;
    assign a_ba = cx1_reg + 8'd1 + py0;
    assign a_bb = cx1_reg + 8'd1 + py1;

    pn2d_ram #(.WIDTH(PERM_WIDTH), .DEPTH(PERM_DEPTH)) u_ram_py0 (
        .clk(clk), .we(tbl_we), .waddr(table_index), .wdata(table_value),
        .raddr(cy_in), .rdata(py0));
    pn2d_ram #(.WIDTH(PERM_WIDTH), .DEPTH(PERM_DEPTH)) u_ram_py1 (
        .clk(clk), .we(tbl_we), .waddr(table_index), .wdata(table_value),
        .raddr(cy_in + 8'd1), .rdata(py1));
    pn2d_ram #(.WIDTH(PERM_WIDTH), .DEPTH(PERM_DEPTH)) u_ram_aa (
        .clk(clk), .we(tbl_we), .waddr(table_index), .wdata(table_value),
        .raddr(a_aa), .rdata(h_aa));
    pn2d_ram #(.WIDTH(PERM_WIDTH), .DEPTH(PERM_DEPTH)) u_ram_ab (
        .clk(clk), .we(tbl_we), .waddr(table_index), .wdata(table_value),
        .raddr(a_ab), .rdata(h_ab));
    pn2d_ram #(.WIDTH(PERM_WIDTH), .DEPTH(PERM_DEPTH)) u_ram_ba (
        .clk(clk), .we(tbl_we), .waddr(table_index), .wdata(table_value),
        .raddr(a_ba), .rdata(h_ba));
    pn2d_ram #(.WIDTH(PERM_WIDTH), .DEPTH(PERM_DEPTH)) u_ram_bb (
        .clk(clk), .we(tbl_we), .waddr(table_index), .wdata(table_value),
        .raddr(a_bb), .rdata(h_bb));

    assign x0 = $signed({2'b00, fx2_reg});
    assign y0 = $signed({2'b00, fy2_reg});
    assign x1 = x0 - 18'sd65536;
    assign y1 = y0 - 18'sd65536;

    assign vld_next = {vld_reg[STAGES-2:0], eval_in};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        // stage 1: fraction, cell, fade first term
        fx1_reg <= frac_q16(x_coord);
        fy1_reg <= frac_q16(y_coord);
        cx1_reg <= 8'(x_coord >>> COORD_FRAC_BITS);
        ax_reg  <= fix_t'($signed({5'b0, frac_q16(x_coord)}) * 6) - fix_t'(15 * 65536);
        ay_reg  <= fix_t'($signed({5'b0, frac_q16(y_coord)}) * 6) - fix_t'(15 * 65536);
        // stage 2
        fx2_reg <= fx1_reg;
        fy2_reg <= fy1_reg;
        bx_reg  <= qmul(fx1_reg, ax_reg) + fix_t'(10 * 65536);
        by_reg  <= qmul(fy1_reg, ay_reg) + fix_t'(10 * 65536);
        // stage 3: corner gradients
        fx3_reg  <= fx2_reg;
        fy3_reg  <= fy2_reg;
        cxf_reg  <= qmul(fx2_reg, bx_reg);
        cyf_reg  <= qmul(fy2_reg, by_reg);
        daa3_reg <= grad(h_aa[3:0], x0, y0);
        dba3_reg <= grad(h_ba[3:0], x1, y0);
        dab3_reg <= grad(h_ab[3:0], x0, y1);
        dbb3_reg <= grad(h_bb[3:0], x1, y1);
        // stage 4
        fx4_reg  <= fx3_reg;
        fy4_reg  <= fy3_reg;
        dx_reg   <= qmul(fx3_reg, cxf_reg);
        dy_reg   <= qmul(fy3_reg, cyf_reg);
        daa4_reg <= daa3_reg;
        dba4_reg <= dba3_reg;
        dab4_reg <= dab3_reg;
        dbb4_reg <= dbb3_reg;
        // stage 5: fade done
        u5_reg   <= qmul(fx4_reg, dx_reg);
        v5_reg   <= qmul(fy4_reg, dy_reg);
        daa5_reg <= daa4_reg;
        dab5_reg <= dab4_reg;
        dba5_reg <= dba4_reg;
        dbb5_reg <= dbb4_reg;
        // stage 6: x lerp products
        p0_reg   <= u5_reg * (40'(dba5_reg) - 40'(daa5_reg));
        p1_reg   <= u5_reg * (40'(dbb5_reg) - 40'(dab5_reg));
        daa6_reg <= daa5_reg;
        dab6_reg <= dab5_reg;
        v6_reg   <= v5_reg;
        // stage 7
        n0_reg <= fix_t'(daa6_reg) + fix_t'(p0_reg >>> 16);
        n1_reg <= fix_t'(dab6_reg) + fix_t'(p1_reg >>> 16);
        v7_reg <= v6_reg;
        // stage 8: y lerp product
        pr_reg   <= v7_reg * (40'(n1_reg) - 40'(n0_reg));
        n0_8_reg <= n0_reg;
        // stage 9
        out_reg <= 19'(n0_8_reg + fix_t'(pr_reg >>> 16));
    end

    assign noise_value = out_reg;
    assign done        = vld_reg[STAGES-1];

endmodule
